/* design/palette_map_serpentine_dither_unit_assert.svh */
// Assertion macros shared by the modules that check their own behavior.
`ifndef PALETTE_MAP_SERPENTINE_DITHER_UNIT_ASSERT_SVH
`define PALETTE_MAP_SERPENTINE_DITHER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PMSD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PMSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pmsd_pkg.sv */
package pmsd_pkg;

    // Default row capacity of the error memories.
    localparam int MAX_WIDTH_DEF = 1024;
    // Palette capacity, searched sixteen entries per cycle.
    localparam int MAX_PALETTE = 256;
    localparam int LANES = 16;
    localparam int PAL_ROWS = MAX_PALETTE / LANES;
    localparam int ROW_W = $clog2(PAL_ROWS);
    localparam int LANE_W = $clog2(LANES);

    localparam int CH = 4;
    localparam int ERR_W = 20;
    localparam int DIST_W = 19;
    localparam int COL_W = 11;
    localparam int CFG_W = 11;
    localparam int IDX_W = 8;

    // Register reset values.
    localparam logic DITHER_RST = 1'b1;
    localparam logic [7:0] MAX_VALUE_RST = 8'd255;
    localparam logic [10:0] WIDTH_RST = 11'd1024;
    localparam logic [8:0] PSIZE_RST = 9'd256;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DITHER = 2'd0;
    localparam logic [1:0] CFG_MAX_VALUE = 2'd1;
    localparam logic [1:0] CFG_WIDTH = 2'd2;
    localparam logic [1:0] CFG_PSIZE = 2'd3;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_FRAME = 2'd2
    } cmd_code_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic in_ready;
        logic rd_err;
        logic adj;
        logic search_init;
        logic search_step;
        logic pal_rd;
        logic err_calc;
        logic upd_w1;
        logic upd_w2;
        logic upd_w3;
        logic finish;
        logic clr_cur;
        logic clr_nxt;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] in_cmd;
        logic dither;
        logic search_last;
        logic search_busy;
        logic clr_last;
        logic out_free;
        logic row_last;
    } dp_status_t;

endpackage

/* design/pmsd_ctrl.sv */
module pmsd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  pmsd_pkg::dp_status_t  sts,
    output pmsd_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_CLR_ALL,
        ST_IDLE,
        ST_RD_ERR,
        ST_ADJ,
        ST_SEARCH,
        ST_DRAIN,
        ST_PAL_RD,
        ST_ERR,
        ST_UPD_W1,
        ST_UPD_W2,
        ST_UPD_W3,
        ST_FINISH,
        ST_CLR_ROW
    } state_t;

    state_t state_reg, state_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR_ALL: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (sts.in_cmd)
                        pmsd_pkg::CMD_PIXEL: state_next = ST_RD_ERR;
                        pmsd_pkg::CMD_FRAME: state_next = ST_CLR_ALL;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_ERR: state_next = ST_ADJ;
            ST_ADJ: state_next = ST_SEARCH;
            ST_SEARCH: begin
                if (sts.search_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!sts.search_busy) state_next = sts.dither ? ST_PAL_RD : ST_FINISH;
            end
            ST_PAL_RD: state_next = ST_ERR;
            ST_ERR: state_next = ST_UPD_W1;
            ST_UPD_W1: state_next = ST_UPD_W2;
            ST_UPD_W2: state_next = ST_UPD_W3;
            ST_UPD_W3: state_next = ST_FINISH;
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = (sts.row_last && sts.dither) ? ST_CLR_ROW : ST_IDLE;
                end
            end
            ST_CLR_ROW: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register; reset starts with a clearing pass of both error rows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_ALL;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    always_comb begin
        cmd = '0;
        cmd.in_ready = (state_reg == ST_IDLE);
        cmd.rd_err = (state_reg == ST_RD_ERR);
        cmd.adj = (state_reg == ST_ADJ);
        cmd.search_init = (state_reg == ST_ADJ);
        cmd.search_step = (state_reg == ST_SEARCH);
        cmd.pal_rd = (state_reg == ST_PAL_RD);
        cmd.err_calc = (state_reg == ST_ERR);
        cmd.upd_w1 = (state_reg == ST_UPD_W1);
        cmd.upd_w2 = (state_reg == ST_UPD_W2);
        cmd.upd_w3 = (state_reg == ST_UPD_W3);
        cmd.finish = (state_reg == ST_FINISH) && sts.out_free;
        cmd.clr_cur = (state_reg == ST_CLR_ALL);
        cmd.clr_nxt = (state_reg == ST_CLR_ALL) || (state_reg == ST_CLR_ROW);
    end

endmodule

/* design/pmsd_dp.sv */
module pmsd_dp #(
    parameter int MAX_WIDTH = pmsd_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [pmsd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_valid,
    input  logic [1:0]                  s_command,
    input  logic [7:0]                  s_entry_number,
    input  logic [7:0]                  s_red,
    input  logic [7:0]                  s_green,
    input  logic [7:0]                  s_blue,
    input  logic [7:0]                  s_alpha,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_color_index,
    output logic                        m_row_end,
    input  pmsd_pkg::ctrl_cmd_t         cmd,
    output pmsd_pkg::dp_status_t        sts
);

    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CW = pmsd_pkg::COL_W;
    localparam int EW = pmsd_pkg::ERR_W;
    localparam int DW = pmsd_pkg::DIST_W;
    localparam int NL = pmsd_pkg::LANES;
    localparam int RW = pmsd_pkg::ROW_W;
    localparam int LW = pmsd_pkg::LANE_W;

    typedef logic signed [EW-1:0] err_t;
    typedef logic [pmsd_pkg::CH-1:0][EW-1:0] err_word_t;
    typedef logic [pmsd_pkg::CH-1:0][7:0] pix_t;

    // Configuration registers.
    logic dither_reg;
    logic [7:0] max_value_reg;
    logic [CW-1:0] width_reg;
    logic [8:0] psize_reg;

    // Frame position state.
    logic [CW-1:0] col_pos_reg;
    logic rev_reg;
    logic sel_reg;

    // Per-pixel registers.
    pix_t px_in_reg, px_adj_reg;
    logic [CW-1:0] pos_reg, col_reg;
    logic last_reg;

    // Search pipeline.
    logic [RW-1:0] row_cnt_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic [RW-1:0] r1_reg, r2_reg;
    logic [NL-1:0][DW-1:0] dist_reg;
    logic [DW-1:0] lane_dist_reg;
    logic [pmsd_pkg::IDX_W-1:0] lane_idx_reg;
    logic [DW-1:0] best_dist_reg;
    logic [pmsd_pkg::IDX_W-1:0] best_idx_reg;

    // Palette memory, one row of sixteen entries per address.
    logic [NL-1:0][31:0] pal_mem [pmsd_pkg::PAL_ROWS];
    logic [NL-1:0][31:0] pal_q;
    logic [RW-1:0] pal_raddr;

    // Error row memories, used as current and next row by sel_reg.
    err_word_t bank0 [DEPTH];
    err_word_t bank1 [DEPTH];
    err_word_t b0_q, b1_q, b0_wdata, b1_wdata;
    logic [SLOT_W-1:0] b0_waddr, b1_waddr, b0_raddr, b1_raddr;
    logic b0_we, b1_we;

    err_word_t cur_q, nxt_q, cur_wdata, nxt_wdata;
    logic [SLOT_W-1:0] cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
    logic cur_we, nxt_we;

    logic [SLOT_W-1:0] clr_addr_reg;

    // Error terms of the current pixel.
    logic [pmsd_pkg::CH-1:0][EW-1:0] t7_reg, t3_reg, t5_reg, t1_reg;

    logic out_valid_reg;
    logic [7:0] out_idx_reg;
    logic out_end_reg;

    logic in_acc;
    logic [CW-1:0] w_eff, wm1, pos_c, col_c;
    logic [8:0] n_eff;
    logic [RW-1:0] last_row;
    logic [CW:0] mid_w, ahead_w, behind_w;
    logic [SLOT_W-1:0] mid_s, ahead_s, behind_s;
    pix_t adj_c;
    logic [NL-1:0][DW-1:0] dist_c;
    logic [DW-1:0] tree_dist;
    logic [LW-1:0] tree_lane;
    logic [pmsd_pkg::CH-1:0][EW-1:0] t7_c, t3_c, t5_c, t1_c;

    // Signed division by 16, truncating toward zero.
    function automatic err_t div16(input logic signed [22:0] x);
        logic signed [22:0] b;
        b = (x + (x[22] ? 23'sd15 : 23'sd0)) >>> 4;
        return b[EW-1:0];
    endfunction

    assign in_acc = s_valid && cmd.in_ready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_reg <= pmsd_pkg::DITHER_RST;
            max_value_reg <= pmsd_pkg::MAX_VALUE_RST;
            width_reg <= pmsd_pkg::WIDTH_RST;
            psize_reg <= pmsd_pkg::PSIZE_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                pmsd_pkg::CFG_DITHER: dither_reg <= cfg_data[0];
                pmsd_pkg::CFG_MAX_VALUE: max_value_reg <= cfg_data[7:0];
                pmsd_pkg::CFG_WIDTH: width_reg <= cfg_data;
                pmsd_pkg::CFG_PSIZE: psize_reg <= cfg_data[8:0];
                default: dither_reg <= dither_reg;
            endcase
        end
    end

    // Effective width, palette size and column of the incoming pixel.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = CW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        wm1 = w_eff - CW'(1);
        pos_c = (col_pos_reg > wm1) ? wm1 : col_pos_reg;
        col_c = rev_reg ? (wm1 - pos_c) : pos_c;
        if (psize_reg == '0) begin
            n_eff = 9'd1;
        end else if (32'(psize_reg) > pmsd_pkg::MAX_PALETTE) begin
            n_eff = 9'(pmsd_pkg::MAX_PALETTE);
        end else begin
            n_eff = psize_reg;
        end
        last_row = RW'((n_eff - 9'd1) >> LW);
    end

    // Error row slots around the pixel's column.
    always_comb begin
        mid_w = {1'b0, col_reg} + (CW+1)'(1);
        ahead_w = rev_reg ? {1'b0, col_reg} : ({1'b0, col_reg} + (CW+1)'(2));
        behind_w = rev_reg ? ({1'b0, col_reg} + (CW+1)'(2)) : {1'b0, col_reg};
        mid_s = SLOT_W'(mid_w);
        ahead_s = SLOT_W'(ahead_w);
        behind_s = SLOT_W'(behind_w);
    end

    // Pixel capture and frame position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            rev_reg <= 1'b0;
            sel_reg <= 1'b0;
        end else if (in_acc && s_command == pmsd_pkg::CMD_FRAME) begin
            col_pos_reg <= '0;
            rev_reg <= 1'b0;
        end else if (cmd.finish) begin
            col_pos_reg <= last_reg ? '0 : (pos_reg + CW'(1));
            if (last_reg && dither_reg) begin
                rev_reg <= !rev_reg;
                sel_reg <= !sel_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            px_in_reg <= {s_alpha, s_blue, s_green, s_red};
            pos_reg <= pos_c;
            col_reg <= col_c;
            last_reg <= (pos_c == wm1);
        end
    end

    // Palette load and row read.
    assign pal_raddr = cmd.pal_rd ? best_idx_reg[pmsd_pkg::IDX_W-1 -: RW] : row_cnt_reg;

    always_ff @(posedge aclk) begin
        if (in_acc && s_command == pmsd_pkg::CMD_LOAD
                && 32'(s_entry_number) < pmsd_pkg::MAX_PALETTE) begin
            pal_mem[s_entry_number[pmsd_pkg::IDX_W-1 -: RW]][s_entry_number[LW-1:0]]
                <= {s_alpha, s_blue, s_green, s_red};
        end
        pal_q <= pal_mem[pal_raddr];
    end

    // Adjusted pixel: diffused error added and clamped when dithering.
    always_comb begin
        err_t e, q, v, mx;
        mx = err_t'({12'b0, max_value_reg});
        adj_c = px_in_reg;
        for (int c = 0; c < pmsd_pkg::CH; c++) begin
            e = err_t'(cur_q[c]);
            q = (e + (e[EW-1] ? err_t'(1023) : err_t'(0))) >>> 10;
            v = err_t'({12'b0, px_in_reg[c]}) + q;
            if (dither_reg) begin
                if (v < 0) begin
                    adj_c[c] = 8'd0;
                end else if (v > mx) begin
                    adj_c[c] = max_value_reg;
                end else begin
                    adj_c[c] = v[7:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.adj) px_adj_reg <= adj_c;
    end

    // Squared distances of the sixteen entries of one palette row.
    always_comb begin
        logic [7:0] ad;
        logic [17:0] sum;
        logic [pmsd_pkg::IDX_W:0] idx;
        for (int l = 0; l < NL; l++) begin
            sum = '0;
            for (int c = 0; c < pmsd_pkg::CH; c++) begin
                ad = (px_adj_reg[c] > pal_q[l][8*c +: 8])
                    ? (px_adj_reg[c] - pal_q[l][8*c +: 8])
                    : (pal_q[l][8*c +: 8] - px_adj_reg[c]);
                sum = sum + 18'(16'(ad * ad));
            end
            idx = {1'b0, r1_reg, LW'(l)};
            dist_c[l] = (idx < n_eff) ? {1'b0, sum} : '1;
        end
    end

    // Minimum over a row; on a tie the lower lane wins.
    always_comb begin
        logic [NL-1:0][DW-1:0] d;
        logic [NL-1:0][LW-1:0] i;
        d = dist_reg;
        for (int l = 0; l < NL; l++) i[l] = LW'(l);
        for (int s = 1; s < NL; s = s * 2) begin
            for (int k = 0; k < NL; k = k + 2 * s) begin
                if (d[k+s] < d[k]) begin
                    d[k] = d[k+s];
                    i[k] = i[k+s];
                end
            end
        end
        tree_dist = d[0];
        tree_lane = i[0];
    end

    // Search pipeline: row read, distances, row minimum, running best.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            row_cnt_reg <= '0;
        end else begin
            v1_reg <= cmd.search_step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.search_init) begin
                row_cnt_reg <= '0;
            end else if (cmd.search_step) begin
                row_cnt_reg <= row_cnt_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        r1_reg <= row_cnt_reg;
        r2_reg <= r1_reg;
        dist_reg <= dist_c;
        lane_dist_reg <= tree_dist;
        lane_idx_reg <= {r2_reg, tree_lane};
        if (cmd.search_init) begin
            best_dist_reg <= '1;
            best_idx_reg <= '0;
        end else if (v3_reg && lane_dist_reg < best_dist_reg) begin
            best_dist_reg <= lane_dist_reg;
            best_idx_reg <= lane_idx_reg;
        end
    end

    // Quantization error terms against the chosen entry.
    always_comb begin
        logic [31:0] ent;
        err_t diff, err;
        logic signed [22:0] e23;
        ent = pal_q[best_idx_reg[LW-1:0]];
        for (int c = 0; c < pmsd_pkg::CH; c++) begin
            diff = err_t'({12'b0, px_adj_reg[c]}) - err_t'({12'b0, ent[8*c +: 8]});
            err = diff <<< 10;
            e23 = {{3{err[EW-1]}}, err};
            t7_c[c] = div16(e23 * 23'sd7);
            t3_c[c] = div16(e23 * 23'sd3);
            t5_c[c] = div16(e23 * 23'sd5);
            t1_c[c] = div16(e23);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_calc) begin
            t7_reg <= t7_c;
            t3_reg <= t3_c;
            t5_reg <= t5_c;
            t1_reg <= t1_c;
        end
    end

    // Clearing sweep address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_nxt) begin
            clr_addr_reg <= sts.clr_last ? '0 : (clr_addr_reg + SLOT_W'(1));
        end
    end

    // Current and next row ports, then mapped onto the two banks.
    assign cur_q = sel_reg ? b1_q : b0_q;
    assign nxt_q = sel_reg ? b0_q : b1_q;

    always_comb begin
        cur_we = cmd.clr_cur || cmd.upd_w1;
        cur_waddr = cmd.clr_cur ? clr_addr_reg : ahead_s;
        cur_raddr = cmd.rd_err ? mid_s : ahead_s;
        nxt_we = cmd.clr_nxt || cmd.upd_w1 || cmd.upd_w2 || cmd.upd_w3;
        if (cmd.clr_nxt) begin
            nxt_waddr = clr_addr_reg;
        end else if (cmd.upd_w1) begin
            nxt_waddr = behind_s;
        end else if (cmd.upd_w2) begin
            nxt_waddr = mid_s;
        end else begin
            nxt_waddr = ahead_s;
        end
        if (cmd.err_calc) begin
            nxt_raddr = behind_s;
        end else if (cmd.upd_w1) begin
            nxt_raddr = mid_s;
        end else begin
            nxt_raddr = ahead_s;
        end
        for (int c = 0; c < pmsd_pkg::CH; c++) begin
            cur_wdata[c] = cmd.clr_cur ? '0 : (cur_q[c] + t7_reg[c]);
            if (cmd.clr_nxt) begin
                nxt_wdata[c] = '0;
            end else if (cmd.upd_w1) begin
                nxt_wdata[c] = nxt_q[c] + t3_reg[c];
            end else if (cmd.upd_w2) begin
                nxt_wdata[c] = nxt_q[c] + t5_reg[c];
            end else begin
                nxt_wdata[c] = nxt_q[c] + t1_reg[c];
            end
        end
        b0_we = sel_reg ? nxt_we : cur_we;
        b0_waddr = sel_reg ? nxt_waddr : cur_waddr;
        b0_wdata = sel_reg ? nxt_wdata : cur_wdata;
        b0_raddr = sel_reg ? nxt_raddr : cur_raddr;
        b1_we = sel_reg ? cur_we : nxt_we;
        b1_waddr = sel_reg ? cur_waddr : nxt_waddr;
        b1_wdata = sel_reg ? cur_wdata : nxt_wdata;
        b1_raddr = sel_reg ? cur_raddr : nxt_raddr;
    end

    always_ff @(posedge aclk) begin
        if (b0_we) bank0[b0_waddr] <= b0_wdata;
        b0_q <= bank0[b0_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b1_we) bank1[b1_waddr] <= b1_wdata;
        b1_q <= bank1[b1_raddr];
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_idx_reg <= best_idx_reg;
            out_end_reg <= last_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_color_index = out_idx_reg;
    assign m_row_end = out_end_reg;

    // Status to the controller.
    always_comb begin
        sts.in_cmd = s_command;
        sts.dither = dither_reg;
        sts.search_last = (row_cnt_reg == last_row);
        sts.search_busy = v1_reg || v2_reg || v3_reg;
        sts.clr_last = (clr_addr_reg == SLOT_W'(DEPTH - 1));
        sts.out_free = !out_valid_reg || m_ready;
        sts.row_last = last_reg;
    end

endmodule

/* design/palette_map_serpentine_dither_unit.sv */
// Channel   Ports                                   Moves
// --------  --------------------------------------  ---------------------------------
// s_        s_valid/s_ready, s_command .. s_alpha   load, pixel or frame-start request
// m_        m_valid/m_ready, m_color_index, ...     one result per pixel request
// cfg_      cfg_write, cfg_index, cfg_data          register write, no wait
//
// A pixel's search compares one 16-entry palette row per cycle, and a dithered
// pixel adds the error-row update steps. Load requests leave s_ready high; a
// frame start, reset and each dithered row end add a clearing pass over the
// MAX_WIDTH + 2 error-row slots with s_ready low.
// Reset is synchronous, active low. A result waiting in the output register does
// not stop the next request from being taken.
`include "palette_map_serpentine_dither_unit_assert.svh"

module palette_map_serpentine_dither_unit #(
    parameter int MAX_WIDTH = pmsd_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [pmsd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_command,
    input  logic [7:0]                  s_entry_number,
    input  logic [7:0]                  s_red,
    input  logic [7:0]                  s_green,
    input  logic [7:0]                  s_blue,
    input  logic [7:0]                  s_alpha,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_color_index,
    output logic                        m_row_end
);

    pmsd_pkg::ctrl_cmd_t cmd;
    pmsd_pkg::dp_status_t sts;

    pmsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    pmsd_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_command      (s_command),
        .s_entry_number (s_entry_number),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_alpha        (s_alpha),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_color_index  (m_color_index),
        .m_row_end      (m_row_end),
        .cmd            (cmd),
        .sts            (sts)
    );

    assign s_ready = cmd.in_ready;

    // A taken pixel request closes the input until its work is done.
    `PMSD_ASSERT_NEXT(a_pixel_closes_input, aclk, aresetn, s_valid && s_ready && s_command == pmsd_pkg::CMD_PIXEL, !s_ready, "input still open after a pixel request")
    // A result is only written when the output register can take it.
    `PMSD_ASSERT_NOW(a_finish_has_room, aclk, aresetn, cmd.finish, sts.out_free, "result written over a waiting result")
    // The error-row update steps never overlap each other or a clearing pass.
    `PMSD_ASSERT_NOW(a_update_steps_exclusive, aclk, aresetn, 1'b1, $onehot0({cmd.err_calc, cmd.upd_w1, cmd.upd_w2, cmd.upd_w3, cmd.clr_nxt}), "error-row update steps overlap")

endmodule
